FILE: rtl/core/key_value_table_assert.svh
// ---------------------------------------------------------------------------
// key_value_table assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef KEY_VALUE_TABLE_ASSERT_SVH
`define KEY_VALUE_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge
`define KVT_ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that cons holds in the cycle after ante
`define KVT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define KVT_ASSERT_ALWAYS(name, expr, msg)
`define KVT_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

FILE: rtl/core/kvt_pkg.sv
// ---------------------------------------------------------------------------
// kvt_pkg
// Shared sizes, request and status codes, and controller/datapath structs.
// ---------------------------------------------------------------------------
`default_nettype none

package kvt_pkg;

  // Table size and field widths
  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 32;
  localparam int KEY_BITS   = 32;
  localparam int DATA_BITS  = 32;
  localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(CAPACITY - 1);

  // Request kinds
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_PRESENT   = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                load;
    logic                rd_en;
    logic [IDX_BITS-1:0] rd_addr;
    logic                commit;
  } kvt_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_stall;
  } kvt_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/kvt_req_if.sv
// ---------------------------------------------------------------------------
// kvt_req_if
// Request channel: kind, key and value with a valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface kvt_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          kind;
  logic signed [kvt_pkg::KEY_BITS-1:0] key;
  logic [kvt_pkg::DATA_BITS-1:0]       value;

  modport source (output valid, output kind, output key, output value, input ready);
  modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/kvt_rsp_if.sv
// ---------------------------------------------------------------------------
// kvt_rsp_if
// Result channel: status and looked-up value with a valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface kvt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [kvt_pkg::DATA_BITS-1:0] value_out;

  modport source (output valid, output status, output value_out, input ready);
  modport sink   (input valid, input status, input value_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/kvt_ctrl.sv
// ---------------------------------------------------------------------------
// kvt_ctrl
// Request sequencer: accept, scan every slot, drain the compare, commit.
// ---------------------------------------------------------------------------
`default_nettype none

module kvt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  kvt_req_if.sink                 in_req,
  input  wire kvt_pkg::kvt_stat_t stat,
  output kvt_pkg::kvt_cmd_t       cmd
);

  `include "key_value_table_assert.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  state_t                       state_r, state_nxt;
  logic [kvt_pkg::IDX_BITS-1:0] addr_r, addr_nxt;

  // Next state and scan address
  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_req.valid) begin
          state_nxt = ST_SCAN;
          addr_nxt  = '0;
        end
      end
      ST_SCAN: begin
        if (addr_r == kvt_pkg::LAST_IDX) begin
          state_nxt = ST_DRAIN;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!stat.out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and scan address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
    end
  end

  // Decode commands
  assign in_req.ready = (state_r == ST_IDLE);
  assign cmd.load     = (state_r == ST_IDLE) && in_req.valid;
  assign cmd.rd_en    = (state_r == ST_SCAN);
  assign cmd.rd_addr  = addr_r;
  assign cmd.commit   = (state_r == ST_COMMIT) && !stat.out_stall;

  `KVT_ASSERT_NEXT(a_accept_starts_scan, in_req.valid && in_req.ready,
                   cmd.rd_en && (cmd.rd_addr == '0), "scan did not start at slot zero")
  `KVT_ASSERT_NEXT(a_commit_returns_idle, cmd.commit, in_req.ready && !cmd.commit,
                   "controller not idle after commit")

endmodule

`default_nettype wire

FILE: rtl/core/kvt_dp.sv
// ---------------------------------------------------------------------------
// kvt_dp
// Table storage, key compare, free-slot search and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module kvt_dp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire kvt_pkg::kvt_cmd_t                   cmd,
  output kvt_pkg::kvt_stat_t                       stat,
  input  wire logic [1:0]                          req_kind,
  input  wire logic signed [kvt_pkg::KEY_BITS-1:0] req_key,
  input  wire logic [kvt_pkg::DATA_BITS-1:0]       req_value,
  kvt_rsp_if.source                                out_rsp
);

  `include "key_value_table_assert.svh"

  localparam int IW = kvt_pkg::IDX_BITS;
  localparam int VW = kvt_pkg::VALUE_BITS;
  localparam int KW = kvt_pkg::KEY_BITS;
  localparam int DW = kvt_pkg::DATA_BITS;

  // Key and value storage, one write and one read port
  logic [KW-1:0] key_mem [kvt_pkg::CAPACITY];
  logic [VW-1:0] val_mem [kvt_pkg::CAPACITY];

  logic [kvt_pkg::CAPACITY-1:0] valid_r;

  // Latched request
  logic [1:0]    kind_r;
  logic [KW-1:0] key_r;
  logic [VW-1:0] value_r;

  // Read and compare stage
  logic [KW-1:0] rd_key_r;
  logic [VW-1:0] rd_val_r;
  logic [IW-1:0] cmp_idx_r;
  logic          cmp_en_r;

  // Scan results
  logic          hit_found_r;
  logic [IW-1:0] hit_idx_r;
  logic [VW-1:0] hit_val_r;
  logic          free_found_r;
  logic [IW-1:0] free_idx_r;

  // Result register
  logic          out_valid_r;
  logic [1:0]    status_r, status_nxt;
  logic [DW-1:0] value_out_r, value_out_nxt;

  logic          slot_valid;
  logic          key_match;
  logic          do_insert;
  logic          do_remove;
  logic [VW+DW-1:0] in_ext;
  logic [VW+DW-1:0] hit_ext;

  // Fit the request value to the stored width and back
  assign in_ext  = {{VW{1'b0}}, req_value};
  assign hit_ext = {{DW{1'b0}}, hit_val_r};

  assign slot_valid = valid_r[cmp_idx_r];
  assign key_match  = slot_valid && (rd_key_r == key_r);

  // Decide the outcome at commit
  always_comb begin
    do_insert     = 1'b0;
    do_remove     = 1'b0;
    status_nxt    = kvt_pkg::STATUS_DONE;
    value_out_nxt = '0;
    unique case (kind_r)
      kvt_pkg::KIND_INSERT: begin
        if (hit_found_r) begin
          status_nxt = kvt_pkg::STATUS_PRESENT;
        end else if (!free_found_r) begin
          status_nxt = kvt_pkg::STATUS_FULL;
        end else begin
          do_insert = 1'b1;
        end
      end
      kvt_pkg::KIND_REMOVE: begin
        if (hit_found_r) begin
          do_remove = 1'b1;
        end else begin
          status_nxt = kvt_pkg::STATUS_NOT_FOUND;
        end
      end
      kvt_pkg::KIND_LOOKUP: begin
        if (hit_found_r) begin
          value_out_nxt = hit_ext[DW-1:0];
        end else begin
          status_nxt = kvt_pkg::STATUS_NOT_FOUND;
        end
      end
      default: begin
        status_nxt = kvt_pkg::STATUS_DONE;
      end
    endcase
  end

  // Write on insert, read during the scan
  always_ff @(posedge clk) begin
    if (cmd.commit && do_insert) begin
      key_mem[free_idx_r] <= key_r;
      val_mem[free_idx_r] <= value_r;
    end
    if (cmd.rd_en) begin
      rd_key_r <= key_mem[cmd.rd_addr];
      rd_val_r <= val_mem[cmd.rd_addr];
    end
  end

  // Control state: valid bits, compare enable, scan flags, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      cmp_en_r     <= 1'b0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      cmp_en_r <= cmd.rd_en;
      if (cmd.load) begin
        hit_found_r  <= 1'b0;
        free_found_r <= 1'b0;
      end else if (cmp_en_r) begin
        if (key_match) begin
          hit_found_r <= 1'b1;
        end
        if (!slot_valid) begin
          free_found_r <= 1'b1;
        end
      end
      if (cmd.commit && do_insert) begin
        valid_r[free_idx_r] <= 1'b1;
      end
      if (cmd.commit && do_remove) begin
        valid_r[hit_idx_r] <= 1'b0;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: request latch, first hit and lowest free slot, result
  always_ff @(posedge clk) begin
    cmp_idx_r <= cmd.rd_addr;
    if (cmd.load) begin
      kind_r  <= req_kind;
      key_r   <= $unsigned(req_key);
      value_r <= in_ext[VW-1:0];
    end
    if (cmp_en_r && key_match && !hit_found_r) begin
      hit_idx_r <= cmp_idx_r;
      hit_val_r <= rd_val_r;
    end
    if (cmp_en_r && !slot_valid && !free_found_r) begin
      free_idx_r <= cmp_idx_r;
    end
    if (cmd.commit) begin
      status_r    <= status_nxt;
      value_out_r <= value_out_nxt;
    end
  end

  assign stat.out_stall    = out_valid_r && !out_rsp.ready;
  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.status    = status_r;
  assign out_rsp.value_out = value_out_r;

  `KVT_ASSERT_NEXT(a_commit_shows_result, cmd.commit, out_valid_r,
                   "result not presented after commit")
  `KVT_ASSERT_ALWAYS(a_commit_when_free, !(cmd.commit && stat.out_stall),
                     "commit while result register is stalled")
  `KVT_ASSERT_ALWAYS(a_full_means_all_valid, !(cmd.commit && !free_found_r) || (&valid_r),
                     "no free slot found although a slot is empty")

endmodule

`default_nettype wire

FILE: rtl/core/key_value_table.sv
// A request is accepted, then every slot is scanned serially through the single read port
// of the key/value memory, the compare drains, and the result is registered at commit.
// A new request is not taken until the last one has committed.
// The next request is taken while a result waits; it holds at commit until that leaves.
// Reset (rst_n low, synchronous) empties the table at once; no clearing pass.
// ---------------------------------------------------------------------------
// key_value_table
// Fixed-capacity associative table: insert, remove and lookup of signed keys.
// ---------------------------------------------------------------------------
`default_nettype none

module key_value_table (
  input  wire logic clk,
  input  wire logic rst_n,
  kvt_req_if.sink   in_req,
  kvt_rsp_if.source out_rsp
);

  kvt_pkg::kvt_cmd_t  cmd;
  kvt_pkg::kvt_stat_t stat;

  // Sequencer
  kvt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .stat   (stat),
    .cmd    (cmd)
  );

  // Storage and compare
  kvt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .req_kind  (in_req.kind),
    .req_key   (in_req.key),
    .req_value (in_req.value),
    .out_rsp   (out_rsp)
  );

endmodule

`default_nettype wire

FILE: bench/key_value_table_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// key_value_table_tb
// Drives insert, remove and lookup requests into the table, predicts every
// status and looked-up value from a shadow table, and checks each result in
// order. Sender and receiver idle at random, and the receiver holds off once.
// ---------------------------------------------------------------------------

module key_value_table_tb;
  import kvt_pkg::*;

  // Kind code that the block ignores
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam int RANDOM_REQUESTS = 1330;
  localparam int POOL_SIZE       = 24;
  localparam int HOLD_OFF_AT     = 1000;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam int MAX_REPORTS     = 30;

  localparam logic signed [KEY_BITS-1:0] KEY_MIN = {1'b1, {(KEY_BITS-1){1'b0}}};
  localparam logic signed [KEY_BITS-1:0] KEY_MAX = {1'b0, {(KEY_BITS-1){1'b1}}};

  typedef struct packed {
    logic [1:0]                 kind;
    logic signed [KEY_BITS-1:0] key;
    logic [DATA_BITS-1:0]       value;
  } table_request_t;

  typedef struct packed {
    table_request_t       req;
    logic [1:0]           status;
    logic [DATA_BITS-1:0] value_out;
  } table_answer_t;

  logic clk;
  logic rst_n;

  kvt_req_if req_ch ();
  kvt_rsp_if rsp_ch ();

  key_value_table i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  // Shadow copy of the table
  logic                  shadow_used  [CAPACITY];
  logic [KEY_BITS-1:0]   shadow_key   [CAPACITY];
  logic [VALUE_BITS-1:0] shadow_value [CAPACITY];

  table_request_t pending_requests [$];
  table_answer_t  expected_answers [$];
  table_request_t current_request;

  int requests_accepted;
  int answers_checked;
  int mismatch_count;
  int hold_cycles_left;
  bit hold_done;
  int status_tally [4];

  // Apply one request to the shadow table and return the answer it produces
  function automatic table_answer_t apply_table_request(input table_request_t r);
    table_answer_t a;
    int hit;
    int free_slot;
    a.req       = r;
    a.status    = STATUS_DONE;
    a.value_out = '0;
    hit         = -1;
    free_slot   = -1;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (shadow_used[i] && shadow_key[i] == r.key) hit = i;
      if (!shadow_used[i]) free_slot = i;
    end
    case (r.kind)
      KIND_INSERT: begin
        if (hit >= 0) begin
          a.status = STATUS_PRESENT;
        end else if (free_slot < 0) begin
          a.status = STATUS_FULL;
        end else begin
          shadow_used[free_slot]  = 1'b1;
          shadow_key[free_slot]   = r.key;
          shadow_value[free_slot] = VALUE_BITS'(r.value);
        end
      end
      KIND_REMOVE: begin
        if (hit < 0) a.status = STATUS_NOT_FOUND;
        else shadow_used[hit] = 1'b0;
      end
      KIND_LOOKUP: begin
        if (hit < 0) a.status = STATUS_NOT_FOUND;
        else a.value_out = DATA_BITS'(shadow_value[hit]);
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_REPORTS) begin
      $display("%0t ERROR answer %0d: %s", $realtime, answers_checked, what);
    end
    mismatch_count++;
  endtask

  function automatic table_request_t make_request(input logic [1:0] kind,
                                                  input logic signed [KEY_BITS-1:0] key,
                                                  input logic [DATA_BITS-1:0] value);
    table_request_t r;
    r.kind  = kind;
    r.key   = key;
    r.value = value;
    return r;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Request driver: hold the offer until accepted, then launch the next one
  always @(posedge clk) begin : drive_requests
    table_request_t next_req;
    logic           next_valid;
    int             idle_pct;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else begin
      next_req   = current_request;
      next_valid = req_ch.valid;
      idle_pct   = (requests_accepted < 450) ? 23 : (requests_accepted < 900) ? 67 : 0;
      if (req_ch.valid && req_ch.ready) begin
        table_answer_t a;
        a = apply_table_request(current_request);
        status_tally[a.status]++;
        expected_answers.push_back(a);
        requests_accepted <= requests_accepted + 1;
        next_valid = 1'b0;
      end
      if (!next_valid && pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_req   = pending_requests.pop_front();
        next_valid = 1'b1;
      end
      current_request = next_req;
      req_ch.valid <= next_valid;
      req_ch.kind  <= next_req.kind;
      req_ch.key   <= next_req.key;
      req_ch.value <= next_req.value;
    end
  end

  // Long receiver hold-off once the sender offers without gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles_left <= 0;
      hold_done        <= 1'b0;
    end else if (!hold_done && requests_accepted == HOLD_OFF_AT) begin
      hold_cycles_left <= HOLD_OFF_CYCLES;
      hold_done        <= 1'b1;
    end else if (hold_cycles_left > 0) begin
      hold_cycles_left <= hold_cycles_left - 1;
    end
  end

  // Result monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin : check_answers
    table_answer_t want;
    int            idle_pct;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      idle_pct = (requests_accepted < 450) ? 67 : (requests_accepted < 900) ? 23 : 0;
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_answers.pop_front();
          if (rsp_ch.status !== want.status) begin
            report_mismatch($sformatf("kind %0d key %0d: status %0d, expected %0d",
                                      want.req.kind, want.req.key, rsp_ch.status,
                                      want.status));
          end
          if (rsp_ch.value_out !== want.value_out) begin
            report_mismatch($sformatf("kind %0d key %0d: value %h, expected %h",
                                      want.req.kind, want.req.key, rsp_ch.value_out,
                                      want.value_out));
          end
        end
        answers_checked++;
      end
      rsp_ch.ready <= (hold_cycles_left == 0) && ($urandom_range(99) >= idle_pct);
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    logic signed [KEY_BITS-1:0] key_pool [POOL_SIZE];
    int                         insert_pct;
    int                         roll;
    logic [1:0]                 kind;
    logic signed [KEY_BITS-1:0] key;

    req_ch.valid = 1'b0;
    req_ch.kind  = KIND_INSERT;
    req_ch.key   = '0;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    current_request   = '0;
    requests_accepted = 0;
    answers_checked   = 0;
    mismatch_count    = 0;
    foreach (status_tally[i]) status_tally[i] = 0;
    foreach (shadow_used[i]) begin
      shadow_used[i]  = 1'b0;
      shadow_key[i]   = '0;
      shadow_value[i] = '0;
    end
    rst_n = 1'b0;

    // Directed: misses on an empty table, extreme keys and values, duplicates
    pending_requests.push_back(make_request(KIND_LOOKUP, 0, '1));
    pending_requests.push_back(make_request(KIND_REMOVE, -1, '0));
    pending_requests.push_back(make_request(KIND_INSERT, KEY_MIN, '0));
    pending_requests.push_back(make_request(KIND_INSERT, KEY_MAX, '1));
    pending_requests.push_back(make_request(KIND_INSERT, 0, 32'ha5a5_a5a5));
    pending_requests.push_back(make_request(KIND_INSERT, -1, 32'h5a5a_5a5a));
    pending_requests.push_back(make_request(KIND_INSERT, KEY_MIN, 32'h0000_1234));
    pending_requests.push_back(make_request(KIND_LOOKUP, KEY_MIN, '0));
    pending_requests.push_back(make_request(KIND_LOOKUP, KEY_MAX, '0));
    pending_requests.push_back(make_request(KIND_UNUSED, KEY_MAX, '1));
    pending_requests.push_back(make_request(KIND_REMOVE, KEY_MAX, '0));
    pending_requests.push_back(make_request(KIND_LOOKUP, KEY_MAX, '0));
    // Fill the table, then insert into it while full, new key and duplicate
    for (int i = 0; i < CAPACITY - 3; i++) begin
      pending_requests.push_back(make_request(KIND_INSERT, 100 + i, $urandom));
    end
    pending_requests.push_back(make_request(KIND_INSERT, 7, 32'hdead_beef));
    pending_requests.push_back(make_request(KIND_INSERT, -1, 32'h0));

    // Random: bursts of biased mixes over a small key pool that is refreshed
    insert_pct = 50;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 200 == 0) begin
        foreach (key_pool[i]) key_pool[i] = $urandom;
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = 0;
        key_pool[3] = -1;
      end
      if (n % 30 == 0) insert_pct = $urandom_range(70, 20);
      roll = $urandom_range(99);
      if (roll < insert_pct) kind = KIND_INSERT;
      else if (roll >= 95) kind = KIND_UNUSED;
      else if ($urandom_range(1) == 0) kind = KIND_REMOVE;
      else kind = KIND_LOOKUP;
      if ($urandom_range(9) == 0) key = $urandom;
      else key = key_pool[$urandom_range(POOL_SIZE - 1)];
      pending_requests.push_back(make_request(kind, key, $urandom));
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: everything offered, accepted and answered, then let the block settle
    while (pending_requests.size() != 0 || req_ch.valid || expected_answers.size() != 0) begin
      @(posedge clk);
    end
    repeat (2 * (CAPACITY + 3)) @(posedge clk);

    $display("Ran %0d requests and checked %0d results under three idling mixes.",
             requests_accepted, answers_checked);
    $display("Outcomes: %0d done, %0d already present, %0d table full, %0d not found.",
             status_tally[STATUS_DONE], status_tally[STATUS_PRESENT],
             status_tally[STATUS_FULL], status_tally[STATUS_NOT_FOUND]);
    if (mismatch_count == 0) begin
      $display("key_value_table: match");
    end else begin
      $display("key_value_table: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(5_000_000);
    $display("Timed out with %0d results outstanding.", expected_answers.size());
    $display("key_value_table: mismatch");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/kvt_pkg.sv
rtl/core/kvt_req_if.sv
rtl/core/kvt_rsp_if.sv
rtl/core/kvt_ctrl.sv
rtl/core/kvt_dp.sv
rtl/core/key_value_table.sv
bench/key_value_table_tb.sv
